>>> src/hrbp_pkg.sv
// ----------------------------------------------------------------------------
// hrbp_pkg: shared types and constants for the HTTP request byte parser
// Parse states, field kinds, status codes, register indexes and limits.
// ----------------------------------------------------------------------------
package hrbp_pkg;

	localparam int unsigned BODY_LIMIT = 65536;
	localparam logic [23:0] MAX24 = 24'hFFFFFF;
	localparam int unsigned LEN_NAME_SIZE = 14;

	typedef enum logic [4:0] {
		ST_METHOD_START, ST_METHOD, ST_PATH, ST_PARAM_NEW, ST_PARAM_NAME,
		ST_PARAM_VALUE, ST_VER_H, ST_VER_T1, ST_VER_T2, ST_VER_P, ST_VER_SLASH,
		ST_MAJ_START, ST_MAJ, ST_MIN_START, ST_MIN, ST_LF1, ST_HDR_NEW,
		ST_HDR_NAME, ST_HDR_SP, ST_HDR_VALUE, ST_LF2, ST_LF3, ST_BODY
	} pstate_t;

	typedef enum logic [1:0] {
		STAT_PART  = 2'd0,
		STAT_DONE  = 2'd1,
		STAT_ERROR = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		K_DELIM = 3'd0, K_METHOD = 3'd1, K_PATH = 3'd2, K_PNAME = 3'd3,
		K_PVALUE = 3'd4, K_HNAME = 3'd5, K_HVALUE = 3'd6, K_BODY = 3'd7
	} kind_t;

	localparam logic [2:0] REG_METHOD_LEN = 3'd0;
	localparam logic [2:0] REG_PATH_LEN = 3'd1;
	localparam logic [2:0] REG_PARAM_CNT = 3'd2;
	localparam logic [2:0] REG_PNAME_LEN = 3'd3;
	localparam logic [2:0] REG_PVALUE_LEN = 3'd4;
	localparam logic [2:0] REG_HDR_CNT = 3'd5;
	localparam logic [2:0] REG_HNAME_LEN = 3'd6;
	localparam logic [2:0] REG_HVALUE_LEN = 3'd7;

	typedef struct packed {
		logic [7:0]  max_method_len;
		logic [15:0] max_path_len;
		logic [7:0]  max_param_count;
		logic [15:0] max_param_name_len;
		logic [15:0] max_param_value_len;
		logic [7:0]  max_header_count;
		logic [15:0] max_header_name_len;
		logic [15:0] max_header_value_len;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  field_kind;
		logic [7:0]  data_byte;
		logic [7:0]  entry_number;
		logic [7:0]  version_major;
		logic [7:0]  version_minor;
		logic [23:0] body_length;
	} result_t;

	// Header name that carries the body length
	function automatic logic [7:0] len_name_char(input logic [3:0] idx);
		case (idx)
			4'd0: len_name_char = "C";
			4'd1: len_name_char = "o";
			4'd2: len_name_char = "n";
			4'd3: len_name_char = "t";
			4'd4: len_name_char = "e";
			4'd5: len_name_char = "n";
			4'd6: len_name_char = "t";
			4'd7: len_name_char = "-";
			4'd8: len_name_char = "L";
			4'd9: len_name_char = "e";
			4'd10: len_name_char = "n";
			4'd11: len_name_char = "g";
			4'd12: len_name_char = "t";
			4'd13: len_name_char = "h";
			default: len_name_char = 8'd0;
		endcase
	endfunction

endpackage

>>> src/hrbp_cfg_regs.sv
// ----------------------------------------------------------------------------
// hrbp_cfg_regs: limit registers
// Holds the eight length and count limits, written through a plain port.
// ----------------------------------------------------------------------------
module hrbp_cfg_regs import hrbp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	assign cfg = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_method_len <= 8'd16;
			cfg_q.max_path_len <= 16'd1024;
			cfg_q.max_param_count <= 8'd32;
			cfg_q.max_param_name_len <= 16'd64;
			cfg_q.max_param_value_len <= 16'd256;
			cfg_q.max_header_count <= 8'd32;
			cfg_q.max_header_name_len <= 16'd64;
			cfg_q.max_header_value_len <= 16'd1024;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_METHOD_LEN: cfg_q.max_method_len <= cfg_data[7:0];
				REG_PATH_LEN: cfg_q.max_path_len <= cfg_data;
				REG_PARAM_CNT: cfg_q.max_param_count <= cfg_data[7:0];
				REG_PNAME_LEN: cfg_q.max_param_name_len <= cfg_data;
				REG_PVALUE_LEN: cfg_q.max_param_value_len <= cfg_data;
				REG_HDR_CNT: cfg_q.max_header_count <= cfg_data[7:0];
				REG_HNAME_LEN: cfg_q.max_header_name_len <= cfg_data;
				REG_HVALUE_LEN: cfg_q.max_header_value_len <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

>>> src/hrbp_core.sv
// ----------------------------------------------------------------------------
// hrbp_core: parse state and per-byte result
// One state transition per byte; the result is computed combinationally
// from the registered state and the accepted byte.
// ----------------------------------------------------------------------------
module hrbp_core import hrbp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] c,
	input  cfg_t       cfg,
	output result_t    res
);

	pstate_t     st_q;
	logic [15:0] flen_q;
	logic [7:0]  pcnt_q, hcnt_q, maj_q, min_q;
	logic [3:0]  mpos_q;
	logic        mat_q, seen_q, open_q;
	logic [23:0] clen_q, bcnt_q;

	pstate_t     st_d;
	logic [15:0] flen_d;
	logic [7:0]  pcnt_d, hcnt_d, maj_d, min_d;
	logic [3:0]  mpos_d;
	logic        mat_d, seen_d, open_d;
	logic [23:0] clen_d, bcnt_d;

	logic        err, done, is_ctl, is_digit, is_letter;
	kind_t       kind;
	logic [7:0]  ent;
	logic [3:0]  dig;
	logic [11:0] maj_acc, min_acc;
	logic [27:0] clen_acc;
	logic [23:0] bcnt_inc;

	assign is_ctl = (c <= 8'd31) || (c == 8'd127);
	assign is_digit = (c >= "0") && (c <= "9");
	assign is_letter = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	assign dig = 4'(c - "0");
	assign maj_acc = 12'({4'd0, maj_q} * 12'd10) + {8'd0, dig};
	assign min_acc = 12'({4'd0, min_q} * 12'd10) + {8'd0, dig};
	assign clen_acc = 28'({4'd0, clen_q} * 28'd10) + {24'd0, dig};

	// next state and result fields
	always_comb begin
		st_d = st_q; flen_d = flen_q; pcnt_d = pcnt_q; hcnt_d = hcnt_q;
		maj_d = maj_q; min_d = min_q; mpos_d = mpos_q; mat_d = mat_q;
		seen_d = seen_q; open_d = open_q; clen_d = clen_q; bcnt_d = bcnt_q;
		err = 1'b0; done = 1'b0; kind = K_DELIM; ent = 8'd0;
		bcnt_inc = bcnt_q;
		case (st_q)
			ST_METHOD_START, ST_METHOD: begin
				if (st_q == ST_METHOD && c == " ") begin
					st_d = ST_PATH; flen_d = 16'd0;
				end else if (c < "A" || c > "Z" || flen_q >= {8'd0, cfg.max_method_len}) begin
					err = 1'b1;
				end else begin
					flen_d = flen_q + 16'd1; st_d = ST_METHOD; kind = K_METHOD;
				end
			end
			ST_PATH: begin
				if (c == " ") st_d = ST_VER_H;
				else if (is_ctl) err = 1'b1;
				else if (c == "?") st_d = ST_PARAM_NEW;
				else if (flen_q >= cfg.max_path_len) err = 1'b1;
				else begin
					flen_d = flen_q + 16'd1; kind = K_PATH;
				end
			end
			ST_PARAM_NEW: begin
				if (is_ctl || pcnt_q >= cfg.max_param_count) err = 1'b1;
				else if (cfg.max_param_name_len == 16'd0) err = 1'b1;
				else begin
					pcnt_d = pcnt_q + 8'd1; flen_d = 16'd1;
					st_d = ST_PARAM_NAME; kind = K_PNAME; ent = pcnt_q;
				end
			end
			ST_PARAM_NAME: begin
				if (c == " ") st_d = ST_VER_H;
				else if (c == "=") begin
					st_d = ST_PARAM_VALUE; flen_d = 16'd0;
				end else if (is_ctl || flen_q >= cfg.max_param_name_len) err = 1'b1;
				else begin
					flen_d = flen_q + 16'd1; kind = K_PNAME; ent = pcnt_q - 8'd1;
				end
			end
			ST_PARAM_VALUE: begin
				if (c == " ") st_d = ST_VER_H;
				else if (c == "&") st_d = ST_PARAM_NEW;
				else if (is_ctl || flen_q >= cfg.max_param_value_len) err = 1'b1;
				else begin
					flen_d = flen_q + 16'd1; kind = K_PVALUE; ent = pcnt_q - 8'd1;
				end
			end
			ST_VER_H: if (c == "H") st_d = ST_VER_T1; else err = 1'b1;
			ST_VER_T1: if (c == "T") st_d = ST_VER_T2; else err = 1'b1;
			ST_VER_T2: if (c == "T") st_d = ST_VER_P; else err = 1'b1;
			ST_VER_P: if (c == "P") st_d = ST_VER_SLASH; else err = 1'b1;
			ST_VER_SLASH: begin
				if (c == "/") begin
					maj_d = 8'd0; min_d = 8'd0; st_d = ST_MAJ_START;
				end else err = 1'b1;
			end
			ST_MAJ_START, ST_MAJ: begin
				if (st_q == ST_MAJ && c == ".") st_d = ST_MIN_START;
				else if (is_digit) begin
					maj_d = (maj_acc > 12'd255) ? 8'd255 : maj_acc[7:0];
					st_d = ST_MAJ;
				end else err = 1'b1;
			end
			ST_MIN_START, ST_MIN: begin
				if (st_q == ST_MIN && c == 8'h0D) st_d = ST_LF1;
				else if (is_digit) begin
					min_d = (min_acc > 12'd255) ? 8'd255 : min_acc[7:0];
					st_d = ST_MIN;
				end else err = 1'b1;
			end
			ST_LF1, ST_LF2: if (c == 8'h0A) st_d = ST_HDR_NEW; else err = 1'b1;
			ST_HDR_NEW: begin
				if (c == 8'h0D) st_d = ST_LF3;
				else if (!is_letter || hcnt_q >= cfg.max_header_count) err = 1'b1;
				else if (cfg.max_header_name_len == 16'd0) err = 1'b1;
				else begin
					hcnt_d = hcnt_q + 8'd1; flen_d = 16'd1;
					mat_d = (c == len_name_char(4'd0)); mpos_d = 4'd1;
					st_d = ST_HDR_NAME; kind = K_HNAME; ent = hcnt_q;
				end
			end
			ST_HDR_NAME: begin
				if (c == ":") begin
					if (mat_q && mpos_q == 4'(LEN_NAME_SIZE) && !seen_q) begin
						seen_d = 1'b1; open_d = 1'b1; clen_d = 24'd0;
					end
					st_d = ST_HDR_SP;
				end else if ((!is_letter && c != "-") || flen_q >= cfg.max_header_name_len)
					err = 1'b1;
				else begin
					flen_d = flen_q + 16'd1;
					if (mat_q && mpos_q < 4'(LEN_NAME_SIZE) && c == len_name_char(mpos_q))
						mpos_d = mpos_q + 4'd1;
					else mat_d = 1'b0;
					kind = K_HNAME; ent = hcnt_q - 8'd1;
				end
			end
			ST_HDR_SP: begin
				if (c == " ") begin
					st_d = ST_HDR_VALUE; flen_d = 16'd0;
				end else begin
					open_d = 1'b0; err = 1'b1;
				end
			end
			ST_HDR_VALUE: begin
				if (c == 8'h0D) begin
					open_d = 1'b0; st_d = ST_LF2;
				end else if (is_ctl || flen_q >= cfg.max_header_value_len) err = 1'b1;
				else begin
					flen_d = flen_q + 16'd1;
					if (open_q) begin
						if (is_digit)
							clen_d = (clen_acc > {4'd0, MAX24}) ? MAX24 : clen_acc[23:0];
						else open_d = 1'b0;
					end
					kind = K_HVALUE; ent = hcnt_q - 8'd1;
				end
			end
			ST_LF3: begin
				if (c != 8'h0A || clen_q >= 24'(BODY_LIMIT)) err = 1'b1;
				else if (clen_q != 24'd0) begin
					bcnt_d = 24'd0; st_d = ST_BODY;
				end else done = 1'b1;
			end
			ST_BODY: begin
				kind = K_BODY;
				if (bcnt_q < clen_q) bcnt_inc = bcnt_q + 24'd1;
				bcnt_d = bcnt_inc;
				if (bcnt_inc >= clen_q) done = 1'b1;
			end
			default: err = 1'b1;
		endcase
		if (err) begin
			kind = K_DELIM; ent = 8'd0;
		end
		res.status = err ? STAT_ERROR : (done ? STAT_DONE : STAT_PART);
		res.field_kind = kind;
		res.data_byte = (kind != K_DELIM) ? c : 8'd0;
		res.entry_number = ent;
		res.version_major = maj_d;
		res.version_minor = min_d;
		res.body_length = clen_d;
		// restart after done or error
		if (err || done) begin
			st_d = ST_METHOD_START; flen_d = 16'd0; pcnt_d = 8'd0; hcnt_d = 8'd0;
			maj_d = 8'd0; min_d = 8'd0; mpos_d = 4'd0; mat_d = 1'b1;
			seen_d = 1'b0; open_d = 1'b0; clen_d = 24'd0; bcnt_d = 24'd0;
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_METHOD_START; flen_q <= 16'd0; pcnt_q <= 8'd0; hcnt_q <= 8'd0;
			maj_q <= 8'd0; min_q <= 8'd0; mpos_q <= 4'd0; mat_q <= 1'b1;
			seen_q <= 1'b0; open_q <= 1'b0; clen_q <= 24'd0; bcnt_q <= 24'd0;
		end else if (step) begin
			st_q <= st_d; flen_q <= flen_d; pcnt_q <= pcnt_d; hcnt_q <= hcnt_d;
			maj_q <= maj_d; min_q <= min_d; mpos_q <= mpos_d; mat_q <= mat_d;
			seen_q <= seen_d; open_q <= open_d; clen_q <= clen_d; bcnt_q <= bcnt_d;
		end
	end

endmodule

>>> src/http_request_byte_parser.sv
// ----------------------------------------------------------------------------
// http_request_byte_parser: HTTP/1.x request byte parser
// Tags every request byte with field kind, entry number and status.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: byte_in with in_valid/in_ready, one byte per transaction.
//   Output channel: out_valid/out_ready carrying one result per input byte.
//   Each accepted byte is registered in an input stage; once the skid
//   register is free, the parse state transition and result are computed
//   from it and land in the result register, or in the skid register.
//   Throughput is one byte per cycle while the receiver does not stall.
//   When the receiver stalls, the result register holds and a skid register
//   takes one more result; the input stage then holds and in_ready drops.
//   Reset clears the parse state to the method start and loads the limit
//   registers with their defaults. Limits must be written through cfg_we,
//   cfg_index and cfg_data only while the parser is idle (not enforced).
//   After a complete request or an error the parser restarts at the method.
// ----------------------------------------------------------------------------
module http_request_byte_parser import hrbp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [2:0]  field_kind,
	output logic [7:0]  data_byte,
	output logic [7:0]  entry_number,
	output logic [7:0]  version_major,
	output logic [7:0]  version_minor,
	output logic [23:0] body_length
);

	cfg_t    cfg;
	result_t res;
	result_t out_q, skid_q;
	logic    out_vld_q, skid_vld_q, vld_s1;
	logic    [7:0] byte_s1;
	logic    step;

	hrbp_cfg_regs u_cfg (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .cfg(cfg)
	);

	// stage 1 byte is processed when the skid slot is free
	assign step = vld_s1 && !skid_vld_q;
	assign in_ready = !vld_s1 || step;

	hrbp_core u_core (
		.clk(clk), .arst_n(arst_n), .step(step), .c(byte_s1), .cfg(cfg), .res(res)
	);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) byte_s1 <= byte_in;
	end

	// result register with skid slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (!out_vld_q || out_ready) begin
				out_vld_q <= skid_vld_q || step;
				skid_vld_q <= 1'b0;
			end else if (step) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || out_ready) begin
			out_q <= skid_vld_q ? skid_q : res;
		end else if (step) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_vld_q;
	assign status = out_q.status;
	assign field_kind = out_q.field_kind;
	assign data_byte = out_q.data_byte;
	assign entry_number = out_q.entry_number;
	assign version_major = out_q.version_major;
	assign version_minor = out_q.version_minor;
	assign body_length = out_q.body_length;

endmodule
